// ===== design/rvp_pkg.sv =====
// Shared constants, types and helpers of the radial vignette pixel block.
package rvp_pkg;

	// Field and register widths
	localparam int POS_W = 12;
	localparam int DIM_W = 13;
	localparam int STR_W = 7;
	localparam int CH_W = 8;
	localparam int IDX_W = 2;

	// Gain fraction bits (Q1.FRAC)
	localparam int FRAC = 16;

	// Register indexes on the write port
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_STRENGTH = 2'd2;

	localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;
	localparam logic [DIM_W-1:0] RST_WIDTH = 13'd640;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [STR_W-1:0] STR_MAX = 7'd100;

	// Front end: distance squared times reciprocal of corner distance squared
	localparam int DIFF_W = DIM_W;
	localparam int D2_W = 2 * DIFF_W + 1;
	localparam int INV_W = 32;
	localparam int PROD_W = D2_W + INV_W;
	localparam int TQ_W = PROD_W - (INV_W - FRAC);
	localparam int T_W = FRAC + 3;
	localparam logic [T_W-1:0] T_MAX = {3'b100, {FRAC{1'b0}}};

	// Square root pipelines: one root bit per stage
	localparam int ROOT_W = FRAC + 2;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	// Back end: d^1.5 times strength, divided by 125
	localparam int P_W = 2 * ROOT_W - FRAC;
	localparam int PS_W = P_W + STR_W;
	localparam int RCP_SHIFT = 32;
	localparam int RCP_W = 26;
	localparam logic [RCP_W-1:0] RCP_125 = RCP_W'((64'd1 << RCP_SHIFT) / 125 + 1);
	localparam int LM_W = PS_W + RCP_W;
	localparam int LOSS_W = LM_W - RCP_SHIFT;
	localparam int GAIN_W = FRAC + 1;
	localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC{1'b0}}};

	// Reciprocal divider
	localparam int M2_W = 2 * DIM_W;
	localparam int REMD_W = M2_W - 1;
	localparam int QUO_W = INV_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
	localparam logic [63:0] RST_M2 = 64'(RST_WIDTH) * 64'(RST_WIDTH)
		+ 64'(RST_HEIGHT) * 64'(RST_HEIGHT);
	localparam logic [INV_W-1:0] INV_RESET = INV_W'((64'd1 << INV_W) / RST_M2);

	// Pipeline depth
	localparam int FRONT_STAGES = 4;
	localparam int BACK_STAGES = 5;
	localparam int LATENCY = FRONT_STAGES + 2 * ROOT_W + BACK_STAGES;

	// Word carried alongside the arithmetic
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [ROOT_W-1:0] root;
	} side_t;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_MAX) ? DIM_MAX : v;
	endfunction

	function automatic logic [STR_W-1:0] sat_strength(input logic [STR_W-1:0] v);
		return (v > STR_MAX) ? STR_MAX : v;
	endfunction

endpackage

// ===== design/rvp_recip.sv =====
// Sequential divider: reciprocal of the squared corner distance.
module rvp_recip (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [rvp_pkg::DIM_W-1:0]     dim_w,
	input  logic [rvp_pkg::DIM_W-1:0]     dim_h,
	output logic                          busy,
	output logic [rvp_pkg::INV_W-1:0]     inv
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} rcp_state_t;

	rcp_state_t state_q;
	logic [rvp_pkg::CNT_W-1:0] cnt_q;
	logic [rvp_pkg::INV_W-1:0] inv_q;
	logic [rvp_pkg::M2_W-1:0] m2_q;
	logic [rvp_pkg::REMD_W-1:0] rem_q;
	logic [rvp_pkg::QUO_W-1:0] quo_q;

	logic [rvp_pkg::M2_W-1:0] m2_c;
	logic [rvp_pkg::M2_W-1:0] rem_sh;
	logic fits;

	assign m2_c = {{rvp_pkg::DIM_W{1'b0}}, dim_w} * {{rvp_pkg::DIM_W{1'b0}}, dim_w}
		+ {{rvp_pkg::DIM_W{1'b0}}, dim_h} * {{rvp_pkg::DIM_W{1'b0}}, dim_h};

	// dividend is 2^32: a single one at the first step, zeros after
	assign rem_sh = {rem_q, (cnt_q == '0)};
	assign fits = (rem_sh >= m2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			inv_q <= rvp_pkg::INV_RESET;
		end else if (load) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rvp_pkg::CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (m2_q == '0) begin
						inv_q <= '0;
					end else if (quo_q[rvp_pkg::QUO_W-1]) begin
						inv_q <= '1;
					end else begin
						inv_q <= quo_q[rvp_pkg::INV_W-1:0];
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			m2_q <= m2_c;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? rvp_pkg::REMD_W'(rem_sh - m2_q) : rem_sh[rvp_pkg::REMD_W-1:0];
			quo_q <= {quo_q[rvp_pkg::QUO_W-2:0], fits};
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign inv = inv_q;

	a_inv_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(inv_q) |-> $past(state_q) == ST_DONE)
		else $error("reciprocal changed outside the done step");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == rvp_pkg::CNT_LAST && !load) |=> state_q == ST_DONE)
		else $error("divider did not finish after its last step");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= rvp_pkg::CNT_LAST)
		else $error("divider step count out of range");

endmodule

// ===== design/rvp_front.sv =====
// Front pipeline: squared distance from centre, scaled to d^2 in fixed point.
module rvp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rvp_pkg::POS_W-1:0]     pos_x,
	input  logic [rvp_pkg::POS_W-1:0]     pos_y,
	input  rvp_pkg::side_t                in_side,
	input  logic [rvp_pkg::DIM_W-1:0]     dim_w,
	input  logic [rvp_pkg::DIM_W-1:0]     dim_h,
	input  logic [rvp_pkg::INV_W-1:0]     inv,
	output logic                          out_valid,
	output logic [rvp_pkg::RAD_W-1:0]     out_rad,
	output rvp_pkg::side_t                out_side
);

	// distance in half pixels: |2*pos - dim|
	function automatic logic [rvp_pkg::DIFF_W-1:0] half_dist(
		input logic [rvp_pkg::POS_W-1:0] pos,
		input logic [rvp_pkg::DIM_W-1:0] dim
	);
		logic [rvp_pkg::DIM_W-1:0] a;
		a = {pos, 1'b0};
		return (a >= dim) ? a - dim : dim - a;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [rvp_pkg::DIFF_W-1:0] dx_s1, dy_s1;
	logic [rvp_pkg::D2_W-1:0] d2_s2;
	logic [rvp_pkg::PROD_W-1:0] prod_s3;
	logic [rvp_pkg::RAD_W-1:0] rad_s4;
	rvp_pkg::side_t side_s1, side_s2, side_s3, side_s4;

	logic [2*rvp_pkg::DIFF_W-1:0] sqx, sqy;
	logic [rvp_pkg::D2_W-1:0] d2_c;
	logic [rvp_pkg::PROD_W-1:0] prod_c;
	logic [rvp_pkg::TQ_W-1:0] tq;
	logic [rvp_pkg::T_W-1:0] t_c;

	assign sqx = {{rvp_pkg::DIFF_W{1'b0}}, dx_s1} * {{rvp_pkg::DIFF_W{1'b0}}, dx_s1};
	assign sqy = {{rvp_pkg::DIFF_W{1'b0}}, dy_s1} * {{rvp_pkg::DIFF_W{1'b0}}, dy_s1};
	assign d2_c = {1'b0, sqx} + {1'b0, sqy};

	assign prod_c = {{rvp_pkg::INV_W{1'b0}}, d2_s2} * {{rvp_pkg::D2_W{1'b0}}, inv};

	// d^2 in Q.FRAC, saturated at 4
	assign tq = prod_s3[rvp_pkg::PROD_W-1:rvp_pkg::INV_W-rvp_pkg::FRAC];
	assign t_c = (tq > rvp_pkg::TQ_W'(rvp_pkg::T_MAX)) ? rvp_pkg::T_MAX
		: tq[rvp_pkg::T_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= half_dist(pos_x, dim_w);
		dy_s1 <= half_dist(pos_y, dim_h);
		side_s1 <= in_side;
		d2_s2 <= d2_c;
		side_s2 <= side_s1;
		prod_s3 <= prod_c;
		side_s3 <= side_s2;
		rad_s4 <= rvp_pkg::RAD_W'({t_c, {rvp_pkg::FRAC{1'b0}}});
		side_s4 <= side_s3;
	end

	assign out_valid = vld_s4;
	assign out_rad = rad_s4;
	assign out_side = side_s4;

endmodule

// ===== design/rvp_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rvp_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rvp_pkg::RAD_W-1:0]     in_rad,
	input  rvp_pkg::side_t                in_side,
	output logic                          out_valid,
	output logic [rvp_pkg::ROOT_W-1:0]    out_root,
	output rvp_pkg::side_t                out_side
);

	logic vld_s [1:rvp_pkg::ROOT_W];
	logic [rvp_pkg::REM_W-1:0] rem_s [1:rvp_pkg::ROOT_W];
	logic [rvp_pkg::ROOT_W-1:0] root_s [1:rvp_pkg::ROOT_W];
	logic [rvp_pkg::RAD_W-1:0] rad_s [1:rvp_pkg::ROOT_W];
	rvp_pkg::side_t side_s [1:rvp_pkg::ROOT_W];

	for (genvar i = 0; i < rvp_pkg::ROOT_W; i++) begin : g_step
		logic vld_c;
		logic [rvp_pkg::REM_W-1:0] rem_c;
		logic [rvp_pkg::ROOT_W-1:0] root_c;
		logic [rvp_pkg::RAD_W-1:0] rad_c;
		rvp_pkg::side_t side_c;
		logic [rvp_pkg::REM_W-1:0] cand;
		logic [rvp_pkg::REM_W-1:0] trial;
		logic fits;

		if (i == 0) begin : g_head
			assign vld_c = in_valid;
			assign rem_c = '0;
			assign root_c = '0;
			assign rad_c = in_rad;
			assign side_c = in_side;
		end else begin : g_body
			assign vld_c = vld_s[i];
			assign rem_c = rem_s[i];
			assign root_c = root_s[i];
			assign rad_c = rad_s[i];
			assign side_c = side_s[i];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cand = {rem_c[rvp_pkg::REM_W-3:0], rad_c[rvp_pkg::RAD_W-1:rvp_pkg::RAD_W-2]};
		assign trial = {root_c, 2'b01};
		assign fits = (cand >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= fits ? cand - trial : cand;
			root_s[i+1] <= {root_c[rvp_pkg::ROOT_W-2:0], fits};
			rad_s[i+1] <= {rad_c[rvp_pkg::RAD_W-3:0], 2'b00};
			side_s[i+1] <= side_c;
		end
	end

	assign out_valid = vld_s[rvp_pkg::ROOT_W];
	assign out_root = root_s[rvp_pkg::ROOT_W];
	assign out_side = side_s[rvp_pkg::ROOT_W];

endmodule

// ===== design/rvp_back.sv =====
// Back pipeline: d^1.5, loss from strength, gain and channel scaling.
module rvp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rvp_pkg::ROOT_W-1:0]    in_root,
	input  rvp_pkg::side_t                in_side,
	input  logic [rvp_pkg::STR_W-1:0]     strength,
	output logic                          out_valid,
	output logic [rvp_pkg::CH_W-1:0]      red,
	output logic [rvp_pkg::CH_W-1:0]      green,
	output logic [rvp_pkg::CH_W-1:0]      blue
);

	function automatic logic [rvp_pkg::CH_W-1:0] scale(
		input logic [rvp_pkg::CH_W-1:0] v,
		input logic [rvp_pkg::GAIN_W-1:0] g
	);
		logic [rvp_pkg::CH_W+rvp_pkg::GAIN_W-1:0] prd;
		prd = {{rvp_pkg::GAIN_W{1'b0}}, v} * {{rvp_pkg::CH_W{1'b0}}, g};
		return prd[rvp_pkg::FRAC+rvp_pkg::CH_W-1:rvp_pkg::FRAC];
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [rvp_pkg::P_W-1:0] p_s1;
	logic [rvp_pkg::PS_W-1:0] ps_s2;
	logic [rvp_pkg::LM_W-1:0] lm_s3;
	logic [rvp_pkg::GAIN_W-1:0] gain_s4;
	rvp_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	logic [rvp_pkg::CH_W-1:0] red_s5, green_s5, blue_s5;

	logic [2*rvp_pkg::ROOT_W-1:0] pp_c;
	logic [rvp_pkg::PS_W-1:0] ps_c;
	logic [rvp_pkg::LM_W-1:0] lm_c;
	logic [rvp_pkg::LOSS_W-1:0] loss;
	logic [rvp_pkg::GAIN_W-1:0] gain_c;

	// d * sqrt(d), both Q.FRAC
	assign pp_c = {{rvp_pkg::ROOT_W{1'b0}}, in_side.root}
		* {{rvp_pkg::ROOT_W{1'b0}}, in_root};
	assign ps_c = {{rvp_pkg::STR_W{1'b0}}, p_s1} * {{rvp_pkg::P_W{1'b0}}, strength};
	// p*S*4/500 = p*S/125, exact reciprocal over the reachable range
	assign lm_c = {{rvp_pkg::RCP_W{1'b0}}, ps_s2} * {{rvp_pkg::PS_W{1'b0}}, rvp_pkg::RCP_125};
	assign loss = lm_s3[rvp_pkg::LM_W-1:rvp_pkg::RCP_SHIFT];
	assign gain_c = (loss >= rvp_pkg::LOSS_W'(rvp_pkg::GAIN_ONE)) ? '0
		: rvp_pkg::GAIN_ONE - loss[rvp_pkg::GAIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= pp_c[2*rvp_pkg::ROOT_W-1:rvp_pkg::FRAC];
		side_s1 <= in_side;
		ps_s2 <= ps_c;
		side_s2 <= side_s1;
		lm_s3 <= lm_c;
		side_s3 <= side_s2;
		gain_s4 <= gain_c;
		side_s4 <= side_s3;
		red_s5 <= scale(side_s4.red, gain_s4);
		green_s5 <= scale(side_s4.green, gain_s4);
		blue_s5 <= scale(side_s4.blue, gain_s4);
	end

	assign out_valid = vld_s5;
	assign red = red_s5;
	assign green = green_s5;
	assign blue = blue_s5;

endmodule

// ===== design/radial_vignette_pixel.sv =====
// Top level of the radial vignette: one RGB pixel word in, one darkened pixel word out.
// A pixel is taken at each clock edge where start is high and busy is low, one per
// clock, and its result shows on red_out/green_out/blue_out with done high for one
// cycle; the receiver cannot stall. The result passes through the four front stages,
// the two 18-stage square-root pipelines (d from d^2, then sqrt d) and the five back
// stages. Writing frame_width or frame_height starts a one-bit-per-cycle divider for the
// reciprocal of the squared corner distance; busy stays high after such a write through
// its load, divide and done states. Strength writes take effect at once.
module radial_vignette_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rvp_pkg::POS_W-1:0]     pos_x,
	input  logic [rvp_pkg::POS_W-1:0]     pos_y,
	input  logic [rvp_pkg::CH_W-1:0]      red_in,
	input  logic [rvp_pkg::CH_W-1:0]      green_in,
	input  logic [rvp_pkg::CH_W-1:0]      blue_in,
	output logic                          done,
	output logic [rvp_pkg::CH_W-1:0]      red_out,
	output logic [rvp_pkg::CH_W-1:0]      green_out,
	output logic [rvp_pkg::CH_W-1:0]      blue_out,
	input  logic                          cfg_we,
	input  logic [rvp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rvp_pkg::DIM_W-1:0]     cfg_data
);

	logic [rvp_pkg::DIM_W-1:0] width_q;
	logic [rvp_pkg::DIM_W-1:0] height_q;
	logic [rvp_pkg::STR_W-1:0] strength_q;

	logic accept;
	logic load;
	logic [rvp_pkg::INV_W-1:0] inv;

	rvp_pkg::side_t side_in;
	logic front_valid;
	logic [rvp_pkg::RAD_W-1:0] front_rad;
	rvp_pkg::side_t front_side;
	logic root1_valid;
	logic [rvp_pkg::ROOT_W-1:0] root1;
	rvp_pkg::side_t root1_side;
	logic [rvp_pkg::RAD_W-1:0] mid_rad;
	rvp_pkg::side_t mid_side;
	logic root2_valid;
	logic [rvp_pkg::ROOT_W-1:0] root2;
	rvp_pkg::side_t root2_side;

	// saturate on write so the datapath sees legal values only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= rvp_pkg::RST_WIDTH;
			height_q <= rvp_pkg::RST_HEIGHT;
			strength_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rvp_pkg::REG_FRAME_WIDTH: width_q <= rvp_pkg::sat_dim(cfg_data);
				rvp_pkg::REG_FRAME_HEIGHT: height_q <= rvp_pkg::sat_dim(cfg_data);
				rvp_pkg::REG_STRENGTH: begin
					strength_q <= rvp_pkg::sat_strength(cfg_data[rvp_pkg::STR_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	assign load = cfg_we && (cfg_index == rvp_pkg::REG_FRAME_WIDTH
		|| cfg_index == rvp_pkg::REG_FRAME_HEIGHT);
	assign accept = start && !busy;

	assign side_in.red = red_in;
	assign side_in.green = green_in;
	assign side_in.blue = blue_in;
	assign side_in.root = '0;

	rvp_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.dim_w  (width_q),
		.dim_h  (height_q),
		.busy   (busy),
		.inv    (inv)
	);

	rvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.in_side   (side_in),
		.dim_w     (width_q),
		.dim_h     (height_q),
		.inv       (inv),
		.out_valid (front_valid),
		.out_rad   (front_rad),
		.out_side  (front_side)
	);

	rvp_isqrt u_sqrt_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_rad    (front_rad),
		.in_side   (front_side),
		.out_valid (root1_valid),
		.out_root  (root1),
		.out_side  (root1_side)
	);

	// d rides along in the side word for the d * sqrt(d) product
	assign mid_rad = rvp_pkg::RAD_W'({root1, {rvp_pkg::FRAC{1'b0}}});
	assign mid_side.red = root1_side.red;
	assign mid_side.green = root1_side.green;
	assign mid_side.blue = root1_side.blue;
	assign mid_side.root = root1;

	rvp_isqrt u_sqrt_sd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root1_valid),
		.in_rad    (mid_rad),
		.in_side   (mid_side),
		.out_valid (root2_valid),
		.out_root  (root2),
		.out_side  (root2_side)
	);

	rvp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root2_valid),
		.in_root   (root2),
		.in_side   (root2_side),
		.strength  (strength_q),
		.out_valid (done),
		.red       (red_out),
		.green     (green_out),
		.blue      (blue_out)
	);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(rvp_pkg::LATENCY) done)
		else $error("accepted pixel produced no result word");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, rvp_pkg::LATENCY))
		else $error("result word without an accepted pixel");

	a_busy_after_dim_write: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy)
		else $error("frame size write did not hold off new pixels");

endmodule
